@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled at the rising clock edge and
// disabled while the synchronous active-low reset is applied.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");

// Consequent must hold in the cycle after the antecedent.
`define SFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

@@ rtl/core/sfrc_pkg.sv @@
// ---------------------------------------------------------------------------
// sfrc_pkg
// Types, codes and the CRC-8 update shared by the stuffed frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package sfrc_pkg;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ByteW    = 8;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcMsb  = 8'h80;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [7:0] StartResetVal  = 8'd2;
  localparam logic [7:0] EndResetVal    = 8'd3;
  localparam logic [7:0] EscapeResetVal = 8'd16;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2,
    REG_NONE   = 2'd3
  } sfrc_reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2
  } sfrc_phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } sfrc_kind_t;

  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_TOO_LONG = 2'd2,
    STAT_EMPTY    = 2'd3
  } sfrc_status_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_marker;
  } sfrc_cfg_t;

  typedef struct packed {
    sfrc_phase_t phase;
    logic [7:0]  byte_count;
    logic        overflow;
  } sfrc_stat_t;

  // One byte of CRC-8, MSB first, no final XOR.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sfrc_if.sv @@
// ---------------------------------------------------------------------------
// sfrc_in_if / sfrc_out_if
// Valid/ready channels for line bytes and for receiver results.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface sfrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       result_kind;
  logic [1:0] frame_status;

  modport source (output valid, output payload_byte, output result_kind,
                  output frame_status, input ready);
  modport sink   (input valid, input payload_byte, input result_kind,
                  input frame_status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfrc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// sfrc_cfg_regs
// APB register file holding the start, end and escape marker values.
// ---------------------------------------------------------------------------
`default_nettype none

module sfrc_cfg_regs
  import sfrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output sfrc_cfg_t                cfg
);

  sfrc_cfg_t     cfg_r;
  sfrc_cfg_t     cfg_nxt;
  sfrc_reg_idx_t idx;
  logic          wr_en;

  assign idx    = sfrc_reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START:  cfg_nxt.start_marker  = pwdata[7:0];
        REG_END:    cfg_nxt.end_marker    = pwdata[7:0];
        REG_ESCAPE: cfg_nxt.escape_marker = pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START:  prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_r.start_marker};
      REG_END:    prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_r.end_marker};
      REG_ESCAPE: prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_r.escape_marker};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker  <= StartResetVal;
      cfg_r.end_marker    <= EndResetVal;
      cfg_r.escape_marker <= EscapeResetVal;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfrc_deframe.sv @@
// ---------------------------------------------------------------------------
// sfrc_deframe
// Input register, frame state with combinational CRC update, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfrc_deframe
  import sfrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sfrc_cfg_t  cfg,
  sfrc_in_if.sink         in_bus,
  sfrc_out_if.source      out_bus,
  output sfrc_stat_t      stat
);

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

  // Input register.
  logic        stage_valid_r;
  logic [7:0]  stage_byte_r;

  // Frame state.
  sfrc_phase_t phase_r,      phase_nxt;
  logic [7:0]  crc_r,        crc_nxt;
  logic [7:0]  held_r,       held_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [7:0]  count_r,      count_nxt;
  logic        ovf_r,        ovf_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  out_payload_r;
  logic        out_kind_r;
  logic [1:0]  out_status_r;

  logic        fire;
  logic        res_valid;
  logic [7:0]  res_payload;
  sfrc_kind_t  res_kind;
  sfrc_status_t res_status;

  assign fire         = stage_valid_r & (~out_valid_r | out_bus.ready);
  assign in_bus.ready = ~stage_valid_r | fire;

  assign out_bus.valid        = out_valid_r;
  assign out_bus.payload_byte = out_payload_r;
  assign out_bus.result_kind  = out_kind_r;
  assign out_bus.frame_status = out_status_r;

  assign stat.phase      = phase_r;
  assign stat.byte_count = count_r;
  assign stat.overflow   = ovf_r;

  always_comb begin
    logic take;
    phase_nxt      = phase_r;
    crc_nxt        = crc_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    res_valid      = 1'b0;
    res_payload    = 8'd0;
    res_kind       = KIND_PAYLOAD;
    res_status     = STAT_GOOD;
    take           = 1'b0;

    unique case (phase_r)
      PH_ESC: begin
        phase_nxt = PH_BODY;
        take      = 1'b1;
      end
      PH_BODY: begin
        if (stage_byte_r == cfg.escape_marker) begin
          phase_nxt = PH_ESC;
        end else if (stage_byte_r == cfg.end_marker) begin
          phase_nxt  = PH_IDLE;
          res_valid  = 1'b1;
          res_kind   = KIND_STATUS;
          if (ovf_r) begin
            res_status = STAT_TOO_LONG;
          end else if (count_r == 8'd0) begin
            res_status = STAT_EMPTY;
          end else if (held_r == crc_r) begin
            res_status = STAT_GOOD;
          end else begin
            res_status = STAT_CRC_ERR;
          end
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (stage_byte_r == cfg.start_marker) begin
          phase_nxt      = PH_BODY;
          crc_nxt        = CrcInit;
          held_nxt       = 8'd0;
          held_valid_nxt = 1'b0;
          count_nxt      = 8'd0;
          ovf_nxt        = 1'b0;
        end
      end
    endcase

    // A frame byte goes into the holding slot and pushes the previous one out.
    if (take) begin
      if (count_r >= MaxBytes) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt      = count_r + 8'd1;
        held_nxt       = stage_byte_r;
        held_valid_nxt = 1'b1;
        if (held_valid_r) begin
          crc_nxt     = crc8_feed(crc_r, held_r);
          res_valid   = 1'b1;
          res_payload = held_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      stage_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready & in_bus.valid) begin
      stage_byte_r <= in_bus.line_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      crc_r        <= CrcInit;
      held_r       <= 8'd0;
      held_valid_r <= 1'b0;
      count_r      <= 8'd0;
      ovf_r        <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      crc_r        <= crc_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire & res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire & res_valid) begin
      out_payload_r <= res_payload;
      out_kind_r    <= res_kind;
      out_status_r  <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/stuffed_frame_receiver_crc8_unit.sv @@
// ---------------------------------------------------------------------------
// stuffed_frame_receiver_crc8_unit
// Byte-stuffed frame receiver with trailing CRC-8 check and frame status.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Contents
//  --------+-----------+------------------------------------------------------
//  in_bus  | sink      | line_byte: one raw byte from the serial line
//  out_bus | source    | payload_byte, result_kind, frame_status
//  cfg_*   | APB slave | start, end and escape marker registers at 0x0/0x4/0x8
//
//  A line byte is taken every cycle while the input ready is high; its result,
//  if it has one, passes from the input register to the result register.
//  The CRC-8 update of one byte is done combinationally between the two.
//  Reset is synchronous and active low; markers return to 2, 3 and 16.
//  A stalled result holds the working stage; one more request fits in the
//  input register before the input ready drops.
//
//  While idle, bytes are dropped until the start marker. Inside a frame an
//  escape makes the next byte literal and an unescaped end marker closes the
//  frame with a status request on the result channel. Frame bytes are passed
//  on one byte late so the trailing CRC byte is held back and compared with
//  the running CRC at the end marker. Once MAX_FRAME_BYTES frame bytes have
//  been counted, further bytes are dropped and the frame reports too long.
// ---------------------------------------------------------------------------
`default_nettype none

module stuffed_frame_receiver_crc8_unit
  import sfrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  sfrc_in_if.sink                  in_bus,
  sfrc_out_if.source               out_bus,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [ApbAddrW-1:0] cfg_paddr,
  input  wire logic [ApbDataW-1:0] cfg_pwdata,
  output logic      [ApbDataW-1:0] cfg_prdata,
  output logic                     cfg_pready
);

`include "assert_macros.svh"

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

  // Marker values as seen by the deframer.
  sfrc_cfg_t  cfg;
  // Frame bookkeeping exported for checking.
  sfrc_stat_t stat;

  sfrc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfrc_deframe #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .stat    (stat)
  );

  // The frame byte counter saturates at the limit.
  `SFRC_ASSERT_SAME(a_count_limit, clk, rst_n, 1'b1, stat.byte_count <= MaxBytes)
  // Overflow is only ever raised after the counter has reached the limit.
  `SFRC_ASSERT_SAME(a_ovf_full, clk, rst_n, stat.overflow, stat.byte_count == MaxBytes)
  // A payload result never carries a status code, and a status result no data.
  `SFRC_ASSERT_SAME(a_payload_clean, clk, rst_n,
                    out_bus.valid && (out_bus.result_kind == KIND_PAYLOAD),
                    out_bus.frame_status == STAT_GOOD)
  `SFRC_ASSERT_SAME(a_status_clean, clk, rst_n,
                    out_bus.valid && (out_bus.result_kind == KIND_STATUS),
                    out_bus.payload_byte == 8'd0)

endmodule

`default_nettype wire
